@@ sv/tcce_pkg.sv @@
// tcce_pkg: shared types, constants and helpers of the text console char engine
// used by the screen memory, the channel interfaces and the top level

package tcce_pkg;

	localparam int COLS      = 80;
	localparam int ROWS      = 25;
	localparam int CELLS     = ROWS * COLS;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int CNT_W     = $clog2(CELLS + 1);
	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int CHAR_W    = 8;
	localparam int ATTR_W    = 8;
	localparam int CELL_W    = CHAR_W + ATTR_W;
	localparam int OP_W      = 2;
	localparam int TAB_NULLS = 4;
	localparam int TAB_W     = $clog2(TAB_NULLS);

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [ATTR_W-1:0] attr_t;
	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [OP_W-1:0]   op_t;
	typedef logic [TAB_W-1:0]  tab_t;

	localparam op_t OP_PUT   = 2'd0;
	localparam op_t OP_READ  = 2'd1;
	localparam op_t OP_CLEAR = 2'd2;

	localparam char_t CH_BS  = 8'h08;
	localparam char_t CH_TAB = 8'h09;
	localparam char_t CH_LF  = 8'h0A;
	localparam char_t CH_CR  = 8'h0D;
	localparam char_t CH_NUL = 8'h00;

	localparam attr_t CLEAR_ATTR  = 8'h0F;
	localparam attr_t COLOR_RESET = 8'h03;

	// one write request to the screen memory
	typedef struct packed {
		logic  en;
		addr_t addr;
		cell_t data;
	} mem_wr_t;

	function automatic addr_t cell_addr(input row_t row, input col_t col);
		return addr_t'(int'(row) * COLS + int'(col));
	endfunction

endpackage

@@ sv/tcce_cmd_if.sv @@
// tcce_cmd_if: command channel of the text console char engine
// valid/ready handshake with the operation fields; uses tcce_pkg

interface tcce_cmd_if;
	logic             valid;
	logic             ready;
	tcce_pkg::op_t    opcode;
	tcce_pkg::char_t  char_code;
	tcce_pkg::row_t   read_row;
	tcce_pkg::col_t   read_col;

	modport source (output valid, opcode, char_code, read_row, read_col, input ready);
	modport sink   (input valid, opcode, char_code, read_row, read_col, output ready);
endinterface

@@ sv/tcce_res_if.sv @@
// tcce_res_if: result channel of the text console char engine
// valid/ready handshake with the cell and cursor fields; uses tcce_pkg

interface tcce_res_if;
	logic             valid;
	logic             ready;
	tcce_pkg::char_t  cell_char;
	tcce_pkg::attr_t  cell_color;
	tcce_pkg::col_t   cursor_col;
	tcce_pkg::row_t   cursor_row;

	modport source (output valid, cell_char, cell_color, cursor_col, cursor_row, input ready);
	modport sink   (input valid, cell_char, cell_color, cursor_col, cursor_row, output ready);
endinterface

@@ sv/tcce_screen_mem.sv @@
// tcce_screen_mem: screen cell store, one write port and one read port
// read data registered, valid the cycle after the address; uses tcce_pkg

module tcce_screen_mem (
	input  logic              clk,
	input  tcce_pkg::mem_wr_t wr,
	input  tcce_pkg::addr_t   raddr,
	output tcce_pkg::cell_t   rdata
);

	tcce_pkg::cell_t mem [tcce_pkg::CELLS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ sv/text_console_char_engine.sv @@
// text_console_char_engine: terminal engine over a 25 x 80 screen of char/attribute cells
// depends on tcce_pkg, tcce_cmd_if, tcce_res_if and tcce_screen_mem
//
// cmd carries one operation per item: put character, read cell or clear screen.
// res returns one item per command: the cell (reads only, else zero) and the cursor.
// cfg_we/cfg_wdata load the attribute used for written and blanked cells.
// An item is taken only while the sequencer is idle, one at a time. The result
// register sits after the sequencer, so a new item is taken while the previous
// result still waits on res.ready; a stalled receiver holds the sequencer only
// once the next result is ready to be loaded.
// After acceptance a read passes the read step; a backspace, carriage return, newline off
// the last row or plain character one put step, where a pending wrap first does the newline
// in a pass of its own; a tab writes TAB_NULLS null cells, wrapping as needed; an unused
// opcode goes straight to done. The next item is taken the cycle after the result loads.
// A newline on the last row, or a wrap there, scrolls: rows 1 to 24 are copied up one row,
// each cell read while the one before is written, then the last row is blanked.
// Clear screen sweeps all 2000 cells, one per cycle, before its result.
// After reset the same clearing pass runs with cmd.ready low;
// the attribute register returns to 0x03 and the cursor to the top left.

module text_console_char_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  tcce_pkg::attr_t   cfg_wdata,
	tcce_cmd_if.sink          cmd,
	tcce_res_if.source        res
);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_PUT    = 7'b0000100,
		S_READ   = 7'b0001000,
		S_SCROLL = 7'b0010000,
		S_BLANK  = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	tcce_pkg::cnt_t    cnt_q, cnt_d;
	tcce_pkg::col_t    col_q, col_d;
	tcce_pkg::row_t    row_q, row_d;
	tcce_pkg::attr_t   color_q;
	tcce_pkg::char_t   ch_q, ch_d;
	tcce_pkg::tab_t    tab_left_q, tab_left_d;
	logic              clr_op_q, clr_op_d;
	logic              rd_ok_q, rd_ok_d;
	tcce_pkg::char_t   cell_char_q, cell_char_d;
	tcce_pkg::attr_t   cell_color_q, cell_color_d;
	logic              copy_s1, copy_d;
	tcce_pkg::addr_t   waddr_s1, waddr_d;
	logic              out_valid_q;
	tcce_pkg::char_t   out_char_q;
	tcce_pkg::attr_t   out_color_q;
	tcce_pkg::col_t    out_col_q;
	tcce_pkg::row_t    out_row_q;

	tcce_pkg::mem_wr_t wr;
	tcce_pkg::addr_t   raddr;
	tcce_pkg::cell_t   rdata;
	logic              accept;
	logic              load_out;
	logic              last_row;
	logic              wrap_pending;

	tcce_screen_mem u_mem (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cmd.ready    = (state_q == S_IDLE);
	assign accept       = cmd.valid && cmd.ready;
	assign last_row     = int'(row_q) >= tcce_pkg::ROWS - 1;
	assign wrap_pending = int'(col_q) >= tcce_pkg::COLS;

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		col_d        = col_q;
		row_d        = row_q;
		ch_d         = ch_q;
		tab_left_d   = tab_left_q;
		clr_op_d     = clr_op_q;
		rd_ok_d      = rd_ok_q;
		cell_char_d  = cell_char_q;
		cell_color_d = cell_color_q;
		copy_d       = 1'b0;
		waddr_d      = waddr_s1;
		load_out     = 1'b0;
		wr           = '0;
		raddr        = tcce_pkg::cell_addr(cmd.read_row, cmd.read_col);

		unique case (state_q)
			S_CLEAR: begin
				wr.en   = 1'b1;
				wr.addr = cnt_q[tcce_pkg::ADDR_W-1:0];
				wr.data = {tcce_pkg::CLEAR_ATTR, tcce_pkg::CH_NUL};
				col_d   = '0;
				row_d   = '0;
				if (cnt_q == tcce_pkg::cnt_t'(tcce_pkg::CELLS - 1)) begin
					cnt_d    = '0;
					clr_op_d = 1'b0;
					state_d  = clr_op_q ? S_DONE : S_IDLE;
				end else begin
					cnt_d = cnt_q + tcce_pkg::cnt_t'(1);
				end
			end
			S_IDLE: begin
				if (accept) begin
					cell_char_d  = '0;
					cell_color_d = '0;
					ch_d         = cmd.char_code;
					tab_left_d   = tcce_pkg::tab_t'(tcce_pkg::TAB_NULLS - 1);
					rd_ok_d      = (int'(cmd.read_row) < tcce_pkg::ROWS) &&
					               (int'(cmd.read_col) < tcce_pkg::COLS);
					unique case (cmd.opcode)
						tcce_pkg::OP_PUT:  state_d = S_PUT;
						tcce_pkg::OP_READ: state_d = S_READ;
						tcce_pkg::OP_CLEAR: begin
							clr_op_d = 1'b1;
							cnt_d    = '0;
							state_d  = S_CLEAR;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_READ: begin
				if (rd_ok_q) begin
					cell_char_d  = rdata[tcce_pkg::CHAR_W-1:0];
					cell_color_d = rdata[tcce_pkg::CELL_W-1:tcce_pkg::CHAR_W];
				end
				state_d = S_DONE;
			end
			S_PUT: begin
				unique case (ch_q)
					tcce_pkg::CH_BS: begin
						if (col_q != '0) begin
							col_d   = col_q - tcce_pkg::col_t'(1);
							wr.en   = 1'b1;
							wr.addr = tcce_pkg::cell_addr(row_q, col_q - tcce_pkg::col_t'(1));
							wr.data = {color_q, tcce_pkg::CH_NUL};
						end
						state_d = S_DONE;
					end
					tcce_pkg::CH_LF: begin
						col_d = '0;
						if (last_row) begin
							cnt_d   = tcce_pkg::cnt_t'(tcce_pkg::COLS);
							state_d = S_SCROLL;
						end else begin
							row_d   = row_q + tcce_pkg::row_t'(1);
							state_d = S_DONE;
						end
					end
					tcce_pkg::CH_CR: begin
						col_d   = '0;
						state_d = S_DONE;
					end
					default: begin
						if (wrap_pending) begin
							// newline first, the write follows on the next pass
							col_d = '0;
							if (last_row) begin
								cnt_d   = tcce_pkg::cnt_t'(tcce_pkg::COLS);
								state_d = S_SCROLL;
							end else begin
								row_d = row_q + tcce_pkg::row_t'(1);
							end
						end else begin
							wr.en   = 1'b1;
							wr.addr = tcce_pkg::cell_addr(row_q, col_q);
							wr.data = {color_q,
							           (ch_q == tcce_pkg::CH_TAB) ? tcce_pkg::CH_NUL : ch_q};
							col_d   = col_q + tcce_pkg::col_t'(1);
							if ((ch_q == tcce_pkg::CH_TAB) && (tab_left_q != '0)) begin
								tab_left_d = tab_left_q - tcce_pkg::tab_t'(1);
							end else begin
								state_d = S_DONE;
							end
						end
					end
				endcase
			end
			S_SCROLL: begin
				// read row r+1 while the cell read last cycle lands one row up
				raddr   = cnt_q[tcce_pkg::ADDR_W-1:0];
				copy_d  = (cnt_q != tcce_pkg::cnt_t'(tcce_pkg::CELLS));
				waddr_d = tcce_pkg::addr_t'(cnt_q - tcce_pkg::cnt_t'(tcce_pkg::COLS));
				if (copy_s1) begin
					wr.en   = 1'b1;
					wr.addr = waddr_s1;
					wr.data = rdata;
				end
				if (cnt_q == tcce_pkg::cnt_t'(tcce_pkg::CELLS)) begin
					cnt_d   = tcce_pkg::cnt_t'((tcce_pkg::ROWS - 1) * tcce_pkg::COLS);
					state_d = S_BLANK;
				end else begin
					cnt_d = cnt_q + tcce_pkg::cnt_t'(1);
				end
			end
			S_BLANK: begin
				wr.en   = 1'b1;
				wr.addr = cnt_q[tcce_pkg::ADDR_W-1:0];
				wr.data = {color_q, tcce_pkg::CH_NUL};
				if (cnt_q == tcce_pkg::cnt_t'(tcce_pkg::CELLS - 1)) begin
					cnt_d   = '0;
					state_d = (ch_q == tcce_pkg::CH_LF) ? S_DONE : S_PUT;
				end else begin
					cnt_d = cnt_q + tcce_pkg::cnt_t'(1);
				end
			end
			S_DONE: begin
				if (!out_valid_q || res.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			color_q     <= tcce_pkg::COLOR_RESET;
			clr_op_q    <= 1'b0;
			copy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			col_q    <= col_d;
			row_q    <= row_d;
			clr_op_q <= clr_op_d;
			copy_s1  <= copy_d;
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ch_q         <= ch_d;
		tab_left_q   <= tab_left_d;
		rd_ok_q      <= rd_ok_d;
		cell_char_q  <= cell_char_d;
		cell_color_q <= cell_color_d;
		waddr_s1     <= waddr_d;
		if (load_out) begin
			out_char_q  <= cell_char_q;
			out_color_q <= cell_color_q;
			out_col_q   <= col_q;
			out_row_q   <= row_q;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.cell_char  = out_char_q;
	assign res.cell_color = out_color_q;
	assign res.cursor_col = out_col_q;
	assign res.cursor_row = out_row_q;

	// cursor stays on the screen, column may reach one past the last for a pending wrap
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(row_q) < tcce_pkg::ROWS)
		else $error("cursor row beyond last row");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(col_q) <= tcce_pkg::COLS)
		else $error("cursor column beyond pending wrap");

	// a copy write in flight only ever lands while the scroll is running
	a_copy_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		copy_s1 |-> (state_q == S_SCROLL))
		else $error("scroll copy write outside scroll");

	// a fresh result only comes from the done step
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result loaded outside done step");

	// no item is taken while the clearing sweep owns the memory
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |=> !$past(accept))
		else $error("item accepted during clear sweep");

endmodule
